### rtl/mhpq_pkg.sv
// ============================================================================
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Holds the capacity, the derived widths, the command and status codes,
// the sequencer states and the input and result word structs.
// ============================================================================
`default_nettype none

package mhpq_pkg;

    // Number of heap slots and the widths that follow from it.
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the words.
    localparam int KEY_W    = 32;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_EXTRACT  = 2'd1,
        CMD_INCREASE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_SMALLER   = 3'd3,
        STAT_BAD_INDEX = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC_CMP,
        ST_EX_LAST,
        ST_EX_LOAD,
        ST_SU,
        ST_SU_CMP,
        ST_SD,
        ST_SD_LEFT,
        ST_SD_RIGHT,
        ST_SD_DEC,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_cmd                       command;
        logic signed [KEY_W-1:0]    key;
        logic [INDEX_W-1:0]         index;
    } t_in_word;

    typedef struct packed {
        t_status                    status;
        logic signed [KEY_W-1:0]    extracted_key;
        logic signed [KEY_W-1:0]    top_key;
        logic                       top_valid;
        logic [COUNT_W-1:0]         element_count;
    } t_out_word;

endpackage

`default_nettype wire

### rtl/max_heap_priority_queue.sv
// ============================================================================
// max_heap_priority_queue: binary max-heap priority queue, signed 32-bit keys
// Array heap in a single-port-read memory, walked by a small sequencer that
// shares one key comparator for sift-up and sift-down.
// ============================================================================
// Each input word is an insert, an extract of the maximum, or an increase of
// the key held at a heap slot, and each one produces exactly one result word
// with a status, the extracted key (zero unless an extract succeeded), the
// root key after the operation (zero when empty), a top-valid flag and the
// element count. The heap lives in a 256 x 32 memory with one write and one
// registered read per cycle; that read port sets the speed. Each sift-up step
// of an insert or an increase reads the parent and then writes back; an
// increase first reads its slot and compares the new key with it. An
// extract reads the root, then the last slot, and then sifts down: every
// sift-down level reads the left child, then the right child, before the
// write-back; a slot with only a left child skips the right-child read.
// Rejected commands (empty, full, bad index), a refused smaller key and the
// unused command code leave the heap untouched. The input side is stalled
// while an operation is in progress. A finished result sits in an output
// register, so the next input word is taken while the previous result is
// still waiting on a stalled output. There is no clearing pass after reset:
// slots at or above the element count are never read for a result.
`default_nettype none

module max_heap_priority_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire mhpq_pkg::t_in_word   i_in,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      mhpq_pkg::t_out_word  o_out
);

    localparam int ADDR_W = mhpq_pkg::ADDR_W;
    localparam int CNT_W  = mhpq_pkg::CNT_W;
    localparam int KEY_W  = mhpq_pkg::KEY_W;
    // Width for comparing a child index (up to 2*CAPACITY) with the count.
    localparam int CH_W   = ADDR_W + 2;
    // Width for comparing the 8-bit index field with the count.
    localparam int IX_W   = CNT_W + mhpq_pkg::INDEX_W;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic signed [KEY_W-1:0]  r_heap [mhpq_pkg::CAPACITY];
    logic signed [KEY_W-1:0]  r_rd_data;

    mhpq_pkg::t_state         r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic signed [KEY_W-1:0]  r_cur, n_cur;
    logic signed [KEY_W-1:0]  r_best_key, n_best_key;
    logic [ADDR_W-1:0]        r_best_idx, n_best_idx;
    mhpq_pkg::t_status        r_status, n_status;
    logic signed [KEY_W-1:0]  r_extr, n_extr;
    logic                     r_out_valid, n_out_valid;
    mhpq_pkg::t_out_word      r_out, n_out;

    // Memory port controls.
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [KEY_W-1:0]  mem_wdata;

    // ------------------------------------------------------------------
    // Address arithmetic and the shared comparator
    // ------------------------------------------------------------------
    logic                     in_acc;
    logic                     out_free;
    logic [ADDR_W-1:0]        parent;
    logic [CH_W-1:0]          left_ix;
    logic [CH_W-1:0]          right_ix;
    logic [CH_W-1:0]          cnt_ch;
    logic                     left_in;
    logic                     right_in;
    logic                     idx_bad;
    logic                     full;
    logic signed [KEY_W-1:0]  cmp_a;
    logic signed [KEY_W-1:0]  cmp_b;
    logic                     cmp_gt;
    logic                     cmp_eq;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign parent   = ADDR_W'((r_pos - ADDR_W'(1)) >> 1);
    assign left_ix  = CH_W'({r_pos, 1'b1});
    assign right_ix = left_ix + CH_W'(1);
    assign cnt_ch   = CH_W'(r_count);
    assign left_in  = left_ix < cnt_ch;
    assign right_in = right_ix < cnt_ch;
    assign idx_bad  = IX_W'(i_in.index) >= IX_W'(r_count);
    assign full     = r_count == CNT_W'(mhpq_pkg::CAPACITY);

    // One comparator: the freshly read slot against the moving key, or
    // against the best candidate found so far when the right child is in.
    assign cmp_a  = r_rd_data;
    assign cmp_b  = (r_state == mhpq_pkg::ST_SD_RIGHT) ? r_best_key : r_cur;
    assign cmp_gt = cmp_a > cmp_b;
    assign cmp_eq = cmp_a == cmp_b;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.command)
                        mhpq_pkg::CMD_INSERT:
                            n_state = full ? mhpq_pkg::ST_FIN : mhpq_pkg::ST_SU;
                        mhpq_pkg::CMD_EXTRACT:
                            n_state = (r_count == '0) ? mhpq_pkg::ST_FIN
                                                      : mhpq_pkg::ST_EX_LAST;
                        mhpq_pkg::CMD_INCREASE:
                            n_state = idx_bad ? mhpq_pkg::ST_FIN
                                              : mhpq_pkg::ST_INC_CMP;
                        default:
                            n_state = mhpq_pkg::ST_FIN;
                    endcase
                end
            end
            mhpq_pkg::ST_INC_CMP: begin
                // Stored key larger than the new one means a rejection.
                n_state = cmp_gt ? mhpq_pkg::ST_FIN : mhpq_pkg::ST_SU;
            end
            mhpq_pkg::ST_EX_LAST:  n_state = mhpq_pkg::ST_EX_LOAD;
            mhpq_pkg::ST_EX_LOAD:  n_state = mhpq_pkg::ST_SD;
            mhpq_pkg::ST_SU: begin
                n_state = (r_pos == '0) ? mhpq_pkg::ST_FIN : mhpq_pkg::ST_SU_CMP;
            end
            mhpq_pkg::ST_SU_CMP: begin
                n_state = (cmp_gt || cmp_eq) ? mhpq_pkg::ST_FIN : mhpq_pkg::ST_SU;
            end
            mhpq_pkg::ST_SD: begin
                n_state = left_in ? mhpq_pkg::ST_SD_LEFT : mhpq_pkg::ST_FIN;
            end
            mhpq_pkg::ST_SD_LEFT: begin
                n_state = right_in ? mhpq_pkg::ST_SD_RIGHT : mhpq_pkg::ST_SD_DEC;
            end
            mhpq_pkg::ST_SD_RIGHT: n_state = mhpq_pkg::ST_SD_DEC;
            mhpq_pkg::ST_SD_DEC: begin
                n_state = (r_best_idx == r_pos) ? mhpq_pkg::ST_FIN : mhpq_pkg::ST_SD;
            end
            mhpq_pkg::ST_FIN:      n_state = mhpq_pkg::ST_OUT;
            mhpq_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = mhpq_pkg::ST_IDLE;
                end
            end
            default:               n_state = mhpq_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: memory port controls and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        mem_re      = 1'b0;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_cur;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_best_key  = r_best_key;
        n_best_idx  = r_best_idx;
        n_status    = r_status;
        n_extr      = r_extr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        unique case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_status = mhpq_pkg::STAT_OK;
                    n_extr   = '0;
                    n_cur    = i_in.key;
                    unique case (i_in.command)
                        mhpq_pkg::CMD_INSERT: begin
                            if (full) begin
                                n_status = mhpq_pkg::STAT_FULL;
                            end else begin
                                n_pos   = ADDR_W'(r_count);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        mhpq_pkg::CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = mhpq_pkg::STAT_EMPTY;
                            end else begin
                                // Fetch the root now; the last slot follows.
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_count   = r_count - CNT_W'(1);
                            end
                        end
                        mhpq_pkg::CMD_INCREASE: begin
                            if (idx_bad) begin
                                n_status = mhpq_pkg::STAT_BAD_INDEX;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = ADDR_W'(i_in.index);
                                n_pos     = ADDR_W'(i_in.index);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mhpq_pkg::ST_INC_CMP: begin
                if (cmp_gt) begin
                    n_status = mhpq_pkg::STAT_SMALLER;
                end
            end
            mhpq_pkg::ST_EX_LAST: begin
                // The count was already lowered, so it addresses the last slot.
                n_extr    = r_rd_data;
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(r_count);
            end
            mhpq_pkg::ST_EX_LOAD: begin
                n_cur = r_rd_data;
                n_pos = '0;
            end
            mhpq_pkg::ST_SU: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = parent;
                end
            end
            mhpq_pkg::ST_SU_CMP: begin
                mem_we = 1'b1;
                if (!(cmp_gt || cmp_eq)) begin
                    // Parent is smaller: it moves down, the key climbs on.
                    mem_wdata = r_rd_data;
                    n_pos     = parent;
                end
            end
            mhpq_pkg::ST_SD: begin
                if (left_in) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(left_ix);
                end else begin
                    mem_we = 1'b1;
                end
            end
            mhpq_pkg::ST_SD_LEFT: begin
                if (cmp_gt) begin
                    n_best_key = r_rd_data;
                    n_best_idx = ADDR_W'(left_ix);
                end else begin
                    n_best_key = r_cur;
                    n_best_idx = r_pos;
                end
                if (right_in) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(right_ix);
                end
            end
            mhpq_pkg::ST_SD_RIGHT: begin
                // Strictly larger only, so the left child wins a tie.
                if (cmp_gt) begin
                    n_best_key = r_rd_data;
                    n_best_idx = ADDR_W'(right_ix);
                end
            end
            mhpq_pkg::ST_SD_DEC: begin
                mem_we = 1'b1;
                if (r_best_idx != r_pos) begin
                    mem_wdata = r_best_key;
                    n_pos     = r_best_idx;
                end
            end
            mhpq_pkg::ST_FIN: begin
                // Every write has landed; read the root for the result.
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            mhpq_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.status            = r_status;
                    n_out.extracted_key     = r_extr;
                    n_out.top_key           = (r_count != '0) ? r_rd_data : '0;
                    n_out.top_valid         = r_count != '0;
                    n_out.element_count     = mhpq_pkg::COUNT_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhpq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_best_key <= n_best_key;
        r_best_idx <= n_best_idx;
        r_status   <= n_status;
        r_extr     <= n_extr;
        r_out      <= n_out;
    end

    // Heap memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_heap[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_heap[mem_raddr];
        end
    end

    assign o_in_stall  = r_state != mhpq_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    // The element count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(mhpq_pkg::CAPACITY))
        else $error("element count above capacity");

    // An accepted word always starts an operation that holds off the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // Top-valid agrees with the count in every result word.
    a_top_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.top_valid == (o_out.element_count != '0)))
        else $error("top_valid disagrees with element_count");

    // A command that fails reports a zero extracted key.
    a_extr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != mhpq_pkg::STAT_OK) |-> (o_out.extracted_key == '0))
        else $error("extracted key set on a failed command");
`endif

endmodule

`default_nettype wire

### tb/max_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// max_heap_priority_queue_tb: self-checking bench for the max-heap queue
// Drives insert, extract and increase-key words through the valid/stall
// input, mirrors every accepted word on a shadow heap to predict the result
// word, and checks each delivered result field by field, in order, under
// several patterns of sender idling and receiver stalls.
// ============================================================================

module max_heap_priority_queue_tb;

    // The fourth command code is not a member of the command enum; the block
    // must treat it as a no-op that still returns one result word.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    // Length of the long receiver hold-off, and the number of clock cycles
    // without any accepted word or taken result after which the run is
    // declared hung. The slowest word (an extract sifting seven levels down to
    // a leaf) is far shorter, so the limit mostly has to cover the hold-off.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 64;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input has a known value from time 0.
    // ------------------------------------------------------------------------
    logic                si_clk_unused_guard;
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    mhpq_pkg::t_in_word  i_in        = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    mhpq_pkg::t_out_word o_out;

    assign si_clk_unused_guard = i_clk;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    max_heap_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // ------------------------------------------------------------------------
    // Shadow heap. It is updated at the edge where each input word is taken,
    // in acceptance order, so it always matches what the block should hold
    // once all earlier words have been processed.
    // ------------------------------------------------------------------------
    logic signed [mhpq_pkg::KEY_W-1:0] shadow_keys [mhpq_pkg::CAPACITY];
    int                                shadow_count = 0;

    // Result words predicted but not yet delivered, oldest first.
    mhpq_pkg::t_out_word heap_replies_due [$];

    int mismatch_count = 0;
    int in_idle_pct    = 0;    // chance per cycle that the sender idles
    int out_stall_pct  = 0;    // chance per cycle that the receiver stalls
    int hold_req_count = 0;    // bumped by a test to ask for a long hold-off
    int hold_ack_count = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    // Moves the key at the given slot toward the root while its parent is
    // strictly smaller. The climb stops at the root without a comparison there.
    function automatic void climb_shadow(input int start);
        int                                pos;
        int                                parent;
        bit                                done;
        logic signed [mhpq_pkg::KEY_W-1:0] tmp;
        pos  = start;
        done = 1'b0;
        while (pos > 0 && !done) begin
            parent = (pos - 1) / 2;
            if (shadow_keys[parent] >= shadow_keys[pos]) begin
                done = 1'b1;
            end else begin
                tmp                 = shadow_keys[parent];
                shadow_keys[parent] = shadow_keys[pos];
                shadow_keys[pos]    = tmp;
                pos                 = parent;
            end
        end
    endfunction

    // Applies one input word to the shadow heap and returns the result word
    // the block has to produce for it.
    function automatic mhpq_pkg::t_out_word apply_heap_cmd(input mhpq_pkg::t_in_word w);
        mhpq_pkg::t_out_word               res;
        logic signed [mhpq_pkg::KEY_W-1:0] key_in;
        logic signed [mhpq_pkg::KEY_W-1:0] tmp;
        int                                pos;
        int                                lft;
        int                                rgt;
        int                                best;
        bit                                done;
        res        = '0;
        res.status = mhpq_pkg::STAT_OK;
        key_in     = w.key;
        case (w.command)
            mhpq_pkg::CMD_INSERT: begin
                if (shadow_count >= mhpq_pkg::CAPACITY) begin
                    res.status = mhpq_pkg::STAT_FULL;
                end else begin
                    shadow_keys[shadow_count] = key_in;
                    shadow_count++;
                    climb_shadow(shadow_count - 1);
                end
            end
            mhpq_pkg::CMD_EXTRACT: begin
                if (shadow_count == 0) begin
                    res.status = mhpq_pkg::STAT_EMPTY;
                end else begin
                    res.extracted_key = shadow_keys[0];
                    shadow_count--;
                    shadow_keys[0] = shadow_keys[shadow_count];
                    // Sift down: a child only replaces its parent when it is
                    // strictly larger, and the left child wins a tie.
                    pos  = 0;
                    done = 1'b0;
                    while (!done) begin
                        lft  = 2 * pos + 1;
                        rgt  = lft + 1;
                        best = pos;
                        if (lft < shadow_count && shadow_keys[lft] > shadow_keys[best]) begin
                            best = lft;
                        end
                        if (rgt < shadow_count && shadow_keys[rgt] > shadow_keys[best]) begin
                            best = rgt;
                        end
                        if (best == pos) begin
                            done = 1'b1;
                        end else begin
                            tmp               = shadow_keys[pos];
                            shadow_keys[pos]  = shadow_keys[best];
                            shadow_keys[best] = tmp;
                            pos               = best;
                        end
                    end
                end
            end
            mhpq_pkg::CMD_INCREASE: begin
                if (int'(w.index) >= shadow_count) begin
                    res.status = mhpq_pkg::STAT_BAD_INDEX;
                end else if (key_in < shadow_keys[w.index]) begin
                    res.status = mhpq_pkg::STAT_SMALLER;
                end else begin
                    shadow_keys[w.index] = key_in;
                    climb_shadow(int'(w.index));
                end
            end
            default: begin
                // The unused code leaves the heap alone and reports success.
            end
        endcase
        res.top_valid     = (shadow_count > 0);
        res.top_key       = (shadow_count > 0) ? shadow_keys[0] : '0;
        res.element_count = mhpq_pkg::COUNT_W'(shadow_count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic mhpq_pkg::t_in_word make_word(
            input logic [1:0] cmd,
            input logic signed [mhpq_pkg::KEY_W-1:0] key,
            input logic [mhpq_pkg::INDEX_W-1:0] idx);
        mhpq_pkg::t_in_word w;
        w.command = mhpq_pkg::t_cmd'(cmd);
        w.key     = key;
        w.index   = idx;
        return w;
    endfunction

    // Keys lean toward the extremes and toward narrow ranges, so that equal
    // keys are common and ties show up in both sift directions.
    function automatic logic signed [mhpq_pkg::KEY_W-1:0] rand_key();
        case ($urandom_range(9))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2:       return $signed($urandom_range(16)) - 8;
            3, 4:    return $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // New key for an increase at a live slot: mostly a raise (often by zero
    // or a little), sometimes a lowered key that must be refused, sometimes
    // anything at all.
    function automatic logic signed [mhpq_pkg::KEY_W-1:0] new_key_for(input int slot);
        longint cur;
        longint next;
        cur = shadow_keys[slot];
        case ($urandom_range(9))
            0:       next = rand_key();
            1:       next = cur - longint'($urandom_range(1, 100));
            2:       next = cur;
            default: next = cur + longint'($urandom_range(0, 5000));
        endcase
        if (next > 64'sd2147483647) begin
            next = 64'sd2147483647;
        end
        if (next < -64'sd2147483648) begin
            next = -64'sd2147483648;
        end
        return next[mhpq_pkg::KEY_W-1:0];
    endfunction

    // One random command word. The insert share shifts with the fill level
    // so the heap wanders over a wide range of sizes without pinning at an
    // end. Fields a command does not use still carry random values.
    function automatic mhpq_pkg::t_in_word random_heap_word();
        int                                pick;
        int                                insert_pct;
        logic [1:0]                        cmd;
        logic signed [mhpq_pkg::KEY_W-1:0] key;
        logic [mhpq_pkg::INDEX_W-1:0]      idx;
        insert_pct = (shadow_count < 12) ? 65 : (shadow_count > 220) ? 25 : 42;
        pick       = $urandom_range(99);
        key        = rand_key();
        idx        = mhpq_pkg::INDEX_W'($urandom_range(255));
        if (pick < 4) begin
            cmd = CMD_UNUSED;
        end else if (pick < 20) begin
            cmd = mhpq_pkg::CMD_INCREASE;
            if (shadow_count > 0 && $urandom_range(9) != 0) begin
                idx = mhpq_pkg::INDEX_W'($urandom_range(shadow_count - 1));
                key = new_key_for(int'(idx));
            end
        end else if (pick < 20 + insert_pct) begin
            cmd = mhpq_pkg::CMD_INSERT;
        end else begin
            cmd = mhpq_pkg::CMD_EXTRACT;
        end
        return make_word(cmd, key, idx);
    endfunction

    // Offers one word and returns at the edge where it was taken. Valid is
    // left high so back-to-back words need no second assignment in the same
    // step; idle cycles and the drain task are what lower it.
    task automatic send_word(input mhpq_pkg::t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        heap_replies_due.push_back(apply_heap_cmd(w));
    endtask

    // Stops offering words and waits until every predicted result has been
    // delivered. Always lets at least one edge pass, so valid never falls
    // and rises again within one step.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (heap_replies_due.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. Stalls at random, or holds off for a long stretch when a
    // test asks for it; the hold-off is counted here so the sender can keep
    // pushing words into the blocked queue meanwhile.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req_count != hold_ack_count) begin
            hold_ack_count <= hold_req_count;
            hold_left      <= HOLD_CYCLES;
            i_out_stall    <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Every result word taken is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        mhpq_pkg::t_out_word want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (heap_replies_due.size() == 0) begin
                report_mismatch("result word with nothing pending", o_out[31:0], '0);
            end else begin
                want = heap_replies_due.pop_front();
                if (o_out.status !== want.status) begin
                    report_mismatch("status", 32'(o_out.status), 32'(want.status));
                end
                if (o_out.extracted_key !== want.extracted_key) begin
                    report_mismatch("extracted_key", o_out.extracted_key,
                                    want.extracted_key);
                end
                if (o_out.top_key !== want.top_key) begin
                    report_mismatch("top_key", o_out.top_key, want.top_key);
                end
                if (o_out.top_valid !== want.top_valid) begin
                    report_mismatch("top_valid", 32'(o_out.top_valid),
                                    32'(want.top_valid));
                end
                if (o_out.element_count !== want.element_count) begin
                    report_mismatch("element_count", 32'(o_out.element_count),
                                    32'(want.element_count));
                end
            end
        end
    end

    // A run where nothing moves on either side for too long is hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Hand-picked words: the empty-heap cases, both key extremes, equal keys,
    // refused and accepted increases (an equal key included), an increase
    // that ties with the root key, the unused code, and extracts
    // that run the heap dry and then underflow.
    task automatic test_directed_cases();
        int n;
        in_idle_pct   = 18;
        out_stall_pct <= 18;
        send_word(make_word(mhpq_pkg::CMD_EXTRACT, KEY_MAX, 8'hff));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, 32'sd5, 8'h00));
        send_word(make_word(CMD_UNUSED, KEY_MIN, 8'h00));
        send_word(make_word(mhpq_pkg::CMD_INSERT, 32'sd0, 8'h00));
        send_word(make_word(mhpq_pkg::CMD_INSERT, KEY_MAX, 8'h00));
        send_word(make_word(mhpq_pkg::CMD_INSERT, KEY_MIN, 8'hff));
        send_word(make_word(mhpq_pkg::CMD_INSERT, 32'sd5, 8'h00));
        send_word(make_word(mhpq_pkg::CMD_INSERT, 32'sd5, 8'h00));
        // Slot equal to the element count, and the highest slot number.
        send_word(make_word(mhpq_pkg::CMD_INCREASE, KEY_MAX, 8'd5));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, KEY_MAX, 8'hff));
        // A smaller key is refused, an equal one is taken.
        send_word(make_word(mhpq_pkg::CMD_INCREASE, KEY_MIN, 8'd4));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, KEY_MIN, 8'd2));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, 32'sd6, 8'd3));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, KEY_MAX, 8'd2));
        send_word(make_word(CMD_UNUSED, KEY_MAX, 8'hff));
        for (n = 0; n < 6; n++) begin
            send_word(make_word(mhpq_pkg::CMD_EXTRACT, 32'sd0, 8'h00));
        end
        wait_for_results();
    endtask

    // Fills every slot, pushes against the full heap, increases at slots 255,
    // 128 and 200, then drains it completely and underflows once.
    task automatic test_fill_and_overflow();
        int n;
        in_idle_pct   = 0;
        out_stall_pct <= 0;
        while (shadow_count < mhpq_pkg::CAPACITY) begin
            send_word(make_word(mhpq_pkg::CMD_INSERT, rand_key(),
                                mhpq_pkg::INDEX_W'($urandom_range(255))));
        end
        send_word(make_word(mhpq_pkg::CMD_INSERT, KEY_MAX, 8'h00));
        send_word(make_word(mhpq_pkg::CMD_INSERT, KEY_MIN, 8'hff));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, KEY_MAX, 8'hff));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, shadow_keys[128], 8'd128));
        send_word(make_word(mhpq_pkg::CMD_INCREASE, new_key_for(200), 8'd200));
        for (n = 0; n <= mhpq_pkg::CAPACITY; n++) begin
            send_word(make_word(mhpq_pkg::CMD_EXTRACT, rand_key(),
                                mhpq_pkg::INDEX_W'($urandom_range(255))));
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the result register fills and the input stalls.
    task automatic test_output_hold();
        int n;
        in_idle_pct    = 0;
        out_stall_pct  <= 0;
        hold_req_count <= hold_req_count + 1;
        for (n = 0; n < 16; n++) begin
            send_word(random_heap_word());
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int n_words, input int idle_pct,
                                       input int stall_pct);
        int n;
        in_idle_pct   = idle_pct;
        out_stall_pct <= stall_pct;
        for (n = 0; n < n_words; n++) begin
            send_word(random_heap_word());
        end
        wait_for_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_fill_and_overflow();
        test_output_hold();
        test_random_traffic(290, 0, 0);
        test_random_traffic(290, 77, 0);
        test_random_traffic(290, 0, 77);
        test_random_traffic(290, 18, 18);

        // Give a stray extra result word time to show up.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (heap_replies_due.size() != 0) begin
            report_mismatch("results never delivered", heap_replies_due.size(), '0);
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
